// ===== design/rbpe_pkg.sv =====
package rbpe_pkg;

  // Width of a homogeneous weight: Q8.8 weight shifted up by eight bits.
  localparam int HW_BITS = 24;
  // Width of the curve parameter, Q1.16.
  localparam int T_BITS = 17;
  localparam logic [T_BITS-1:0] T_ONE = 17'h10000;
  // Width of one result coordinate, Q10.6.
  localparam int OUT_BITS = 16;
  localparam int ADDR_BITS = 2;
  localparam logic [ADDR_BITS-1:0] REG_POINT_COUNT = 2'd0;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [6:0]  point_index;
    logic [9:0]  point_x;
    logic [9:0]  point_y;
    logic [15:0] point_weight;
    logic [16:0] eval_t;
  } req_t;

  typedef struct packed {
    logic [15:0] curve_x;
    logic [15:0] curve_y;
    logic        empty_flag;
  } res_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [OUT_BITS-1:0] quo;
  } div_stat_t;

endpackage

// ===== design/rbpe_mul.sv =====
module rbpe_mul #(
  parameter int AW = 35
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [17:0]   b,
  output logic signed [AW+17:0] prod,
  output logic signed [AW+17:0] rnd
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // Round to nearest and drop the sixteen fraction bits of the parameter.
  assign rnd = (prod + (AW+18)'(32768)) >>> 16;

endmodule

// ===== design/rbpe_div.sv =====
module rbpe_div #(
  parameter int NUMW = 34
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [NUMW-1:0]                 num,
  input  logic [rbpe_pkg::HW_BITS-1:0]    den,
  output rbpe_pkg::div_stat_t             stat
);

  localparam int DW = NUMW + 7;
  localparam int RW = rbpe_pkg::HW_BITS + 1;
  localparam int OB = rbpe_pkg::OUT_BITS;

  logic [DW-1:0] nval;
  logic [DW-1:0] dlim;
  logic [RW-1:0] rem;
  logic [RW-1:0] rtry;
  logic [OB-1:0] nlo;
  logic [OB-1:0] quo;
  logic [4:0]    cnt;
  logic          busy;
  logic          done;

  assign nval = {1'b0, num, 6'b0} + DW'(den >> 1);
  assign dlim = DW'({den, 16'b0});
  assign rtry = {rem[RW-2:0], nlo[OB-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (nval >= dlim) begin
          quo  <= '1;
          done <= 1'b1;
        end else begin
          rem  <= RW'(nval >> 16);
          nlo  <= nval[OB-1:0];
          quo  <= '0;
          cnt  <= 5'd16;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (rtry >= RW'(den)) begin
          rem <= rtry - RW'(den);
          quo <= {quo[OB-2:0], 1'b1};
        end else begin
          rem <= rtry;
          quo <= {quo[OB-2:0], 1'b0};
        end
        nlo <= {nlo[OB-2:0], 1'b0};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.quo  = quo;

endmodule

// ===== design/rational_bezier_point_eval.sv =====
// An evaluate request with n points in use spends its time in the single shared
// multiplier that does every de Casteljau blend, three per element per round, and in
// the bit-serial divider.
// A point write is taken while idle; a count of zero or one skips the reduction and division.
// Throughput: one request at a time; req_stall is high until the result is loaded.
// Reset (rst, synchronous) clears the sequencer, the result valid and point_count.
module rational_bezier_point_eval #(
  parameter int MAX_POINTS = 128,
  parameter int COORD_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  rbpe_pkg::req_t                     req,
  output logic                               res_valid,
  input  logic                               res_stall,
  output rbpe_pkg::res_t                     res,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rbpe_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  // Homogeneous coordinates: x*w<<8 needs COORD_BITS+24 bits, the weight 24.
  localparam int HX = COORD_BITS + 24;
  localparam int HWB = rbpe_pkg::HW_BITS;
  localparam int IW = $clog2(MAX_POINTS);
  localparam int SW = 2 * COORD_BITS + 16;
  localparam int MW = 2 * HX + HWB;
  localparam int OB = rbpe_pkg::OUT_BITS;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILL0 = 4'd1;
  localparam logic [3:0] S_FILL1 = 4'd2;
  localparam logic [3:0] S_RRD0  = 4'd3;
  localparam logic [3:0] S_RLD   = 4'd4;
  localparam logic [3:0] S_RRD   = 4'd5;
  localparam logic [3:0] S_RMUL  = 4'd6;
  localparam logic [3:0] S_DRD   = 4'd7;
  localparam logic [3:0] S_DLD   = 4'd8;
  localparam logic [3:0] S_DX0   = 4'd9;
  localparam logic [3:0] S_DX1   = 4'd10;
  localparam logic [3:0] S_DY0   = 4'd11;
  localparam logic [3:0] S_DY1   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state;
  logic [1:0] ph;
  logic [IW-1:0] ptr;
  logic [IW-1:0] len;
  logic [rbpe_pkg::T_BITS-1:0] treg;
  logic [7:0] point_count;

  // Control point store, x in the top field, then y, then the weight.
  logic [SW-1:0] pstore [MAX_POINTS];
  logic [SW-1:0] st_q;
  // Working array of homogeneous points, reduced in place round by round.
  logic [MW-1:0] wmem [MAX_POINTS];
  logic [MW-1:0] wq;

  logic [COORD_BITS-1:0] st_x;
  logic [COORD_BITS-1:0] st_y;
  logic [15:0]           st_w;
  logic [HX-1:0]  cur_hx;
  logic [HX-1:0]  cur_hy;
  logic [HWB-1:0] cur_hw;
  logic [HX-1:0]  prev_hx;
  logic [HX-1:0]  prev_hy;
  logic [HWB-1:0] prev_hw;
  logic [HX-1:0]  nx;
  logic [HX-1:0]  ny;
  logic [HX-1:0]  hx_f;

  logic [OB-1:0] res_x;
  logic [OB-1:0] res_y;
  logic          res_e;

  logic signed [HX:0]    mul_a;
  logic signed [17:0]    mul_b;
  logic signed [HX+18:0] mul_prod;
  logic signed [HX+18:0] mul_rnd;

  logic                 div_start;
  logic [HX-1:0]        div_num;
  rbpe_pkg::div_stat_t  div_st;

  logic [8:0] ncl;
  logic       req_acc;
  logic       cfg_wr;
  logic       out_free;

  assign st_x = st_q[SW-1 -: COORD_BITS];
  assign st_y = st_q[SW-1-COORD_BITS -: COORD_BITS];
  assign st_w = st_q[15:0];
  assign cur_hx = wq[MW-1 -: HX];
  assign cur_hy = wq[MW-1-HX -: HX];
  assign cur_hw = wq[HWB-1:0];

  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign out_free  = !res_valid || !res_stall;

  // Configuration: one register; the low address bit is not decoded.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[1] == rbpe_pkg::REG_POINT_COUNT[1]);
  assign prdata = (paddr[1] == rbpe_pkg::REG_POINT_COUNT[1]) ? {24'b0, point_count} : 32'b0;

  // Point count in use, limited to the store depth.
  assign ncl = ({1'b0, point_count} > 9'(MAX_POINTS)) ? 9'(MAX_POINTS) : {1'b0, point_count};

  function automatic logic [OB-1:0] coord_q6(input logic [COORD_BITS-1:0] c);
    logic [COORD_BITS+5:0] q;
    q = {c, 6'b0};
    coord_q6 = (q > (COORD_BITS+6)'(16'hFFFF)) ? '1 : OB'(q);
  endfunction

  // Operand selection for the shared multiplier. During the fill it forms x*w and
  // y*w; during the reduction it forms (b - a) * t for each lane of a blend.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_FILL1) begin
      mul_b = {2'b0, st_w};
      if (ph == 2'd0) begin
        mul_a = (HX+1)'(st_x);
      end else begin
        mul_a = (HX+1)'(st_y);
      end
    end else if (state == S_RMUL) begin
      mul_b = {1'b0, treg};
      case (ph)
        2'd0: mul_a = $signed({1'b0, cur_hx}) - $signed({1'b0, prev_hx});
        2'd1: mul_a = $signed({1'b0, cur_hy}) - $signed({1'b0, prev_hy});
        2'd2: mul_a = $signed((HX+1)'(cur_hw)) - $signed((HX+1)'(prev_hw));
        default: mul_a = '0;
      endcase
    end
  end

  rbpe_mul #(.AW(HX + 1)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod),
    .rnd  (mul_rnd)
  );

  assign div_start = (state == S_DX0) || (state == S_DY0);
  assign div_num   = (state == S_DY0) ? prev_hy : prev_hx;

  rbpe_div #(.NUMW(HX)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (prev_hw),
    .stat  (div_st)
  );

  // Registered reads of both memories at the walk pointer.
  always_ff @(posedge clk) begin
    st_q <= pstore[ptr];
    wq   <= wmem[ptr];
    if (req_acc && req.mode == rbpe_pkg::MODE_WRITE && 32'(req.point_index) < MAX_POINTS) begin
      pstore[IW'(req.point_index)] <= {COORD_BITS'(req.point_x), COORD_BITS'(req.point_y),
                                       req.point_weight};
    end
    if (state == S_FILL1 && ph == 2'd2) begin
      wmem[ptr] <= {hx_f, mul_prod[HX-9:0], 8'b0, st_w, 8'b0};
    end else if (state == S_RMUL && ph == 2'd3) begin
      wmem[ptr - IW'(1)] <= {nx, ny, prev_hw + mul_rnd[HWB-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 8'd0;
    end else if (cfg_wr) begin
      point_count <= pwdata[7:0];
    end
  end

  // Sequencer: fill, n-1 reduction rounds, then two divisions if the weight is not zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ph        <= 2'd0;
      res_valid <= 1'b0;
    end else begin
      // The result stage reloads the output itself when the old result leaves.
      if (res_valid && !res_stall && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_acc && req.mode == rbpe_pkg::MODE_EVAL) begin
            treg  <= (req.eval_t > rbpe_pkg::T_ONE) ? rbpe_pkg::T_ONE : req.eval_t;
            res_e <= 1'b0;
            ptr   <= '0;
            ph    <= 2'd0;
            if (ncl == 9'd0) begin
              res_x <= '0;
              res_y <= '0;
              res_e <= 1'b1;
              state <= S_OUT;
            end else begin
              len   <= IW'(ncl - 9'd1);
              state <= S_FILL0;
            end
          end
        end
        S_FILL0: begin
          state <= S_FILL1;
        end
        S_FILL1: begin
          if (len == '0) begin
            res_x <= coord_q6(st_x);
            res_y <= coord_q6(st_y);
            state <= S_OUT;
          end else begin
            ph <= ph + 2'd1;
            if (ph == 2'd1) begin
              hx_f <= {mul_prod[HX-9:0], 8'b0};
            end
            if (ph == 2'd2) begin
              ph <= 2'd0;
              if (ptr == len) begin
                ptr   <= '0;
                state <= S_RRD0;
              end else begin
                ptr   <= ptr + IW'(1);
                state <= S_FILL0;
              end
            end
          end
        end
        S_RRD0: begin
          state <= S_RLD;
        end
        S_RLD: begin
          prev_hx <= cur_hx;
          prev_hy <= cur_hy;
          prev_hw <= cur_hw;
          ptr     <= IW'(1);
          state   <= S_RRD;
        end
        S_RRD: begin
          ph    <= 2'd0;
          state <= S_RMUL;
        end
        S_RMUL: begin
          ph <= ph + 2'd1;
          if (ph == 2'd1) begin
            nx <= prev_hx + mul_rnd[HX-1:0];
          end
          if (ph == 2'd2) begin
            ny <= prev_hy + mul_rnd[HX-1:0];
          end
          if (ph == 2'd3) begin
            prev_hx <= cur_hx;
            prev_hy <= cur_hy;
            prev_hw <= cur_hw;
            if (ptr == len) begin
              len <= len - IW'(1);
              ptr <= '0;
              if (len == IW'(1)) begin
                state <= S_DRD;
              end else begin
                state <= S_RRD0;
              end
            end else begin
              ptr   <= ptr + IW'(1);
              state <= S_RRD;
            end
          end
        end
        S_DRD: begin
          state <= S_DLD;
        end
        S_DLD: begin
          prev_hx <= cur_hx;
          prev_hy <= cur_hy;
          prev_hw <= cur_hw;
          if (cur_hw == '0) begin
            res_x <= '0;
            res_y <= '0;
            state <= S_OUT;
          end else begin
            state <= S_DX0;
          end
        end
        S_DX0: begin
          state <= S_DX1;
        end
        S_DX1: begin
          if (div_st.done) begin
            res_x <= div_st.quo;
            state <= S_DY0;
          end
        end
        S_DY0: begin
          state <= S_DY1;
        end
        S_DY1: begin
          if (div_st.done) begin
            res_y <= div_st.quo;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            res_valid      <= 1'b1;
            res.curve_x    <= res_x;
            res.curve_y    <= res_y;
            res.empty_flag <= res_e;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // An evaluate request with no points in use goes straight to the result stage.
  a_empty_path: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.mode == rbpe_pkg::MODE_EVAL && point_count == 8'd0) |=> (state == S_OUT))
    else $error("empty evaluate did not go to result stage");

  // The divider finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_DX1 || state == S_DY1))
    else $error("divider finished outside a division wait");

  // A new result appears only after the result stage.
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == S_OUT))
    else $error("result valid raised outside result stage");

  // The divider is never started while it is still busy.
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

// Testbench for the rational Bezier point evaluator.
// Requests are driven at the falling edge and every accepted request is run
// through a local predictor that keeps its own copy of the control point store
// and of point_count. Each evaluate request pushes one expected curve point.
// A checker process compares every accepted result with the oldest expected
// point, field by field.
module tb_top;

  logic                           clk;
  logic                           rst;
  logic                           req_valid;
  logic                           req_stall;
  rbpe_pkg::req_t                 req;
  logic                           res_valid;
  logic                           res_stall;
  rbpe_pkg::res_t                 res;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [rbpe_pkg::ADDR_BITS-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  rational_bezier_point_eval dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: the control point store and the point count.
  int unsigned pt_x [128];
  int unsigned pt_y [128];
  int unsigned pt_w [128];
  int unsigned pt_count;

  rbpe_pkg::res_t curve_q[$];      // curve points still to come out of the block
  int   n_errors;
  int   n_evals;
  int   n_writes;
  int   n_results;
  bit   idle_on;         // random gaps and stalls enabled
  int   hold_cycles;     // long receiver hold-off requested by a test

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ratio in Q10.6, rounded to nearest and saturated.
  function automatic logic [15:0] ratio_q6(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = ((num << 6) + (den >> 1)) / den;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  // Homogeneous de Casteljau reduction followed by rounded divisions of x and y by the weight.
  function automatic rbpe_pkg::res_t curve_point(rbpe_pkg::req_t r);
    rbpe_pkg::res_t  o;
    longint unsigned hx [128];
    longint unsigned hy [128];
    longint unsigned hw [128];
    longint unsigned t;
    int              n;
    o = '0;
    n = (pt_count > 128) ? 128 : pt_count;
    if (n == 0) begin
      o.empty_flag = 1'b1;
    end else if (n == 1) begin
      o.curve_x = 16'(pt_x[0] << 6);
      o.curve_y = 16'(pt_y[0] << 6);
    end else begin
      t = r.eval_t;
      if (t > 65536) t = 65536;
      for (int i = 0; i < n; i++) begin
        hw[i] = longint'(pt_w[i]) << 8;
        hx[i] = (longint'(pt_x[i]) * pt_w[i]) << 8;
        hy[i] = (longint'(pt_y[i]) * pt_w[i]) << 8;
      end
      for (int k = 1; k < n; k++) begin
        for (int i = 0; i + k < n; i++) begin
          hx[i] = (hx[i] * (65536 - t) + hx[i+1] * t + 32768) >> 16;
          hy[i] = (hy[i] * (65536 - t) + hy[i+1] * t + 32768) >> 16;
          hw[i] = (hw[i] * (65536 - t) + hw[i+1] * t + 32768) >> 16;
        end
      end
      if (hw[0] != 0) begin
        o.curve_x = ratio_q6(hx[0], hw[0]);
        o.curve_y = ratio_q6(hy[0], hw[0]);
      end
    end
    return o;
  endfunction

  // Sends one request. Valid is left high after acceptance so that a
  // back-to-back request never lowers and raises it within one time step.
  task automatic send_request(rbpe_pkg::req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req = r;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    if (r.mode == rbpe_pkg::MODE_WRITE) begin
      n_writes++;
      pt_x[r.point_index] = r.point_x;
      pt_y[r.point_index] = r.point_y;
      pt_w[r.point_index] = r.point_weight;
    end else begin
      n_evals++;
      curve_q.push_back(curve_point(r));
    end
    @(negedge clk);
  endtask

  task automatic idle_sender();
    req_valid = 1'b0;
  endtask

  task automatic write_point(int idx, int x, int y, int w);
    rbpe_pkg::req_t r;
    r = '0;
    r.mode = rbpe_pkg::MODE_WRITE;
    r.point_index = 7'(idx);
    r.point_x = 10'(x);
    r.point_y = 10'(y);
    r.point_weight = 16'(w);
    r.eval_t = 17'($urandom_range(0, 65536));
    send_request(r);
  endtask

  task automatic eval_at(int t);
    rbpe_pkg::req_t r;
    r = rbpe_pkg::req_t'($bits(rbpe_pkg::req_t)'({$urandom, $urandom}));
    r.mode = rbpe_pkg::MODE_EVAL;
    r.eval_t = 17'(t);
    send_request(r);
  endtask

  // Waits until the block has nothing left to deliver. A trailing point
  // write may still be in flight, so the wait goes on past the last result.
  task automatic drain();
    idle_sender();
    while (curve_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Register write with setup and access cycles, then a read-back check.
  task automatic set_point_count(int n);
    drain();
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = rbpe_pkg::REG_POINT_COUNT; pwdata = n;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    pwrite = 1'b0; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata[7:0] != n[7:0]) begin
      $error("point_count read-back: expected %0d, got %0d", n, prdata[7:0]);
      n_errors++;
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
    pt_count = n;
  endtask

  // Receiver: random stall bursts, plus a long hold-off when asked.
  initial begin : receiver
    int burst;
    burst = 0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        res_stall = 1'b1;
        hold_cycles--;
      end else if (burst > 0) begin
        res_stall = 1'b1;
        burst--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        res_stall = 1'b1;
        burst = $urandom_range(0, 2);
      end else begin
        res_stall = 1'b0;
      end
    end
  end

  // Result checker: one accepted result against the oldest expected point.
  always @(posedge clk) begin
    rbpe_pkg::res_t e;
    if (!rst && res_valid && !res_stall) begin
      n_results++;
      if (curve_q.size() == 0) begin
        $error("unexpected result x=%0d y=%0d empty=%0d",
               res.curve_x, res.curve_y, res.empty_flag);
        n_errors++;
      end else begin
        e = curve_q.pop_front();
        if (res.curve_x !== e.curve_x) begin
          $error("curve_x: expected %0d, got %0d", e.curve_x, res.curve_x);
          n_errors++;
        end
        if (res.curve_y !== e.curve_y) begin
          $error("curve_y: expected %0d, got %0d", e.curve_y, res.curve_y);
          n_errors++;
        end
        if (res.empty_flag !== e.empty_flag) begin
          $error("empty_flag: expected %0d, got %0d", e.empty_flag, res.empty_flag);
          n_errors++;
        end
      end
    end
  end

  // Every store entry is written first, so no evaluation reads an unwritten one.
  task automatic test_fill_store();
    write_point(0, 1023, 1023, 65535);
    write_point(1, 0, 0, 1);
    for (int i = 2; i < 128; i++)
      write_point(i, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(1, 65535));
  endtask

  // Empty store, a single point, endpoints, extreme weights, the full store.
  task automatic test_directed();
    eval_at(32768);
    set_point_count(1);
    eval_at(0);
    write_point(0, 1023, 0, 1);
    eval_at(65536);
    set_point_count(2);
    write_point(0, 0, 1023, 65535);
    write_point(1, 1023, 0, 1);
    eval_at(0);
    eval_at(65536);
    eval_at(32768);
    eval_at(1);
    eval_at(65535);
    write_point(1, 1023, 1023, 65535);
    eval_at(43690);
    write_point(0, 0, 0, 256);
    eval_at(21845);
    set_point_count(128);
    eval_at($urandom_range(0, 65536));
    set_point_count(0);
    eval_at(65536);
  endtask

  // The receiver holds off while the sender keeps offering, then the sender
  // pauses until every point has come back.
  task automatic test_backpressure();
    set_point_count(3);
    hold_cycles = 400;
    repeat (6) eval_at($urandom_range(0, 65536));
    drain();
  endtask

  task automatic random_item();
    if ($urandom_range(0, 1) == 0)
      write_point($urandom_range(0, 127), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(1, 65535));
    else
      eval_at($urandom_range(0, 65536));
  endtask

  // Random phases, mostly with small counts; phases that start with fewer than 150 items to go have no idling.
  task automatic test_random(int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(0, 1);
        1:       n = $urandom_range(9, 24);
        default: n = $urandom_range(2, 8);
      endcase
      if (items - sent < 150) idle_on = 1'b0;
      set_point_count(n);
      repeat ($urandom_range(20, 60)) begin
        random_item();
        sent++;
      end
    end
  endtask

  initial begin : limit
    #20ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    n_errors = 0; n_evals = 0; n_writes = 0; n_results = 0;
    idle_on = 1'b1; hold_cycles = 0; pt_count = 0;
    req_valid = 1'b0; req = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_fill_store();
    test_directed();
    test_backpressure();
    test_random(1000);
    drain();
    repeat (50) @(posedge clk);
    $display("Covered %0d point writes and %0d evaluations, %0d results checked,",
             n_writes, n_evals, n_results);
    $display("with point counts from 0 to 128 and both sides stalling.");
    if (n_errors == 0 && curve_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
